>>> sv/cbl_pkg.sv
// Package for the CIDR block-list matcher: request/result types, FSM states,
// table sizing constants and the prefix mask helper. No dependencies.
`default_nettype none

package cbl_pkg;

  localparam int unsigned MaxRanges = 16;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned PlenW     = 6;
  localparam int unsigned IdxW      = $clog2(MaxRanges > 1 ? MaxRanges : 2);
  localparam int unsigned CntW      = $clog2(MaxRanges + 1);
  localparam int unsigned EntryW    = 2 * AddrW;

  localparam logic [PlenW-1:0] AddrBitsP = PlenW'(AddrW);

  typedef enum logic {
    OpAdd   = 1'b0,
    OpCheck = 1'b1
  } cbl_op_e;

  typedef enum logic {
    CblIdle = 1'b0,
    CblScan = 1'b1
  } cbl_state_e;

  typedef struct packed {
    cbl_op_e          op;
    logic [AddrW-1:0] addr;
    logic [PlenW-1:0] prefix_len;
  } cbl_req_t;

  typedef struct packed {
    logic blocked;
    logic full_res;
  } cbl_res_t;

  typedef struct packed {
    logic     valid;
    cbl_res_t res;
  } cbl_out_t;

  typedef struct packed {
    logic              we;
    logic [IdxW-1:0]   waddr;
    logic [EntryW-1:0] wdata;
    logic              re;
    logic [IdxW-1:0]   raddr;
  } cbl_ram_ctrl_t;

  function automatic logic [AddrW-1:0] prefix_mask(input logic [PlenW-1:0] plen);
    logic [PlenW-1:0] p;
    logic [PlenW-1:0] sh;
    p  = (plen > AddrBitsP) ? AddrBitsP : plen;
    sh = AddrBitsP - p;
    if (p == '0) begin
      return '0;
    end
    return {AddrW{1'b1}} << sh;
  endfunction

endpackage

`default_nettype wire

>>> sv/cidr_block_list_matcher_core.sv
// Add: done_o is registered and rises in the cycle after the request. Check:
// done_o follows the walk of the N stored ranges and comes earlier on a hit.
// Throughput: one add per cycle while no check holds busy; a check holds busy
// for the one-read-per-cycle walk of the range RAM.
// Reset clears the range count and the sequencer; the range RAM is not cleared.
// Results appear on done_o/res_o for one cycle; the receiver cannot stall.
`default_nettype none

module cidr_block_list_matcher_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire cbl_pkg::cbl_req_t req_i,
  output logic                   done_o,
  output cbl_pkg::cbl_res_t      res_o
);

  cbl_pkg::cbl_ram_ctrl_t        ram_ctrl;
  logic [cbl_pkg::EntryW-1:0]    rdata;
  cbl_pkg::cbl_out_t             out;
  logic                          done_q;
  cbl_pkg::cbl_res_t             res_q;

  cbl_ram #(
    .Width (cbl_pkg::EntryW),
    .Depth (cbl_pkg::MaxRanges)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_ctrl.we),
    .waddr_i (ram_ctrl.waddr),
    .wdata_i (ram_ctrl.wdata),
    .re_i    (ram_ctrl.re),
    .raddr_i (ram_ctrl.raddr),
    .rdata_o (rdata)
  );

  cbl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .ram_o   (ram_ctrl),
    .rdata_i (rdata),
    .out_o   (out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out.valid) begin
      res_q <= out.res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> sv/cbl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module cbl_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = $clog2(Depth > 1 ? Depth : 2)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/cbl_ctrl.sv
// Request sequencer: appends ranges, walks the range table for checks.
// Depends on cbl_pkg; drives the range RAM through cbl_ram_ctrl_t.
`default_nettype none

module cbl_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire cbl_pkg::cbl_req_t             req_i,
  output cbl_pkg::cbl_ram_ctrl_t             ram_o,
  input  wire logic [cbl_pkg::EntryW-1:0]    rdata_i,
  output cbl_pkg::cbl_out_t                  out_o
);

  cbl_pkg::cbl_state_e             state_q, state_d;
  logic [cbl_pkg::CntW-1:0]        count_q, count_d;
  logic [cbl_pkg::CntW-1:0]        idx_q, idx_d;
  logic                            pend_q, pend_d;
  logic [cbl_pkg::AddrW-1:0]       addr_q, addr_d;

  logic [cbl_pkg::AddrW-1:0] mask, lo, hi, rd_lo, rd_hi;
  logic                      room, hit;

  assign mask  = cbl_pkg::prefix_mask(req_i.prefix_len);
  assign lo    = req_i.addr & mask;
  assign hi    = lo | ~mask;
  assign room  = count_q < cbl_pkg::CntW'(cbl_pkg::MaxRanges);
  assign rd_lo = rdata_i[cbl_pkg::EntryW-1:cbl_pkg::AddrW];
  assign rd_hi = rdata_i[cbl_pkg::AddrW-1:0];
  assign hit   = pend_q && (addr_q >= rd_lo) && (addr_q <= rd_hi);
  assign busy  = (state_q != cbl_pkg::CblIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbl_pkg::CblIdle;
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    addr_d    = addr_q;
    ram_o     = '0;
    ram_o.raddr = idx_q[cbl_pkg::IdxW-1:0];
    ram_o.waddr = count_q[cbl_pkg::IdxW-1:0];
    ram_o.wdata = {lo, hi};
    out_o     = '0;
    case (state_q)
      cbl_pkg::CblIdle: begin
        if (start) begin
          if (req_i.op == cbl_pkg::OpAdd) begin
            if (room) begin
              ram_o.we = 1'b1;
              count_d  = count_q + 1'b1;
            end
            out_o.valid        = 1'b1;
            out_o.res.full_res = !room;
          end else begin
            addr_d  = req_i.addr;
            idx_d   = '0;
            pend_d  = 1'b0;
            state_d = cbl_pkg::CblScan;
          end
        end
      end
      cbl_pkg::CblScan: begin
        if (hit) begin
          out_o.valid       = 1'b1;
          out_o.res.blocked = 1'b1;
          pend_d            = 1'b0;
          state_d           = cbl_pkg::CblIdle;
        end else if (idx_q == count_q) begin
          out_o.valid = 1'b1;
          pend_d      = 1'b0;
          state_d     = cbl_pkg::CblIdle;
        end else begin
          ram_o.re = 1'b1;
          idx_d    = idx_q + 1'b1;
          pend_d   = 1'b1;
        end
      end
      default: begin
        state_d = cbl_pkg::CblIdle;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cbl_pkg::CntW'(cbl_pkg::MaxRanges))
    else $error("range count above table depth");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= count_q)
    else $error("scan index past stored ranges");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_o.we |-> (state_q == cbl_pkg::CblIdle) && room && !ram_o.re)
    else $error("range write outside an accepted add");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbl_pkg::CblScan) && (idx_q == count_q) |=>
      (state_q == cbl_pkg::CblIdle))
    else $error("scan did not finish at last range");

endmodule

`default_nettype wire

>>> dv/tb_cidr_block_list_matcher_core.sv
// Self-checking testbench for cidr_block_list_matcher_core: directed and random add/check
// requests, with a scoreboard class that tracks the range list and checks every result.
// Depends on cbl_pkg and the core RTL only.
`default_nettype none

module tb_cidr_block_list_matcher_core;
  import cbl_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainCycles = MaxRanges + 8;

  class cidr_range_scoreboard;
    logic [AddrW-1:0] lo_addr [MaxRanges];
    logic [AddrW-1:0] hi_addr [MaxRanges];
    int unsigned      stored;
    cbl_res_t         expected_verdicts[$];
    int unsigned      errors;
    int unsigned      n_adds, n_drops, n_checks, n_hits;

    function void note_request(cbl_req_t r);
      cbl_res_t         v;
      logic [AddrW-1:0] mask;
      logic [AddrW-1:0] lo;
      logic [PlenW-1:0] p;
      v = '0;
      if (r.op == OpAdd) begin
        n_adds++;
        p    = (r.prefix_len > PlenW'(AddrW)) ? PlenW'(AddrW) : r.prefix_len;
        mask = AddrW'(64'hFFFF_FFFF_0000_0000 >> p);
        lo   = r.addr & mask;
        if (stored < MaxRanges) begin
          lo_addr[stored] = lo;
          hi_addr[stored] = lo | ~mask;
          stored++;
        end else begin
          v.full_res = 1'b1;
          n_drops++;
        end
      end else begin
        n_checks++;
        for (int unsigned i = 0; i < stored; i++) begin
          if (r.addr >= lo_addr[i] && r.addr <= hi_addr[i]) begin
            v.blocked = 1'b1;
          end
        end
        if (v.blocked) n_hits++;
      end
      expected_verdicts = {expected_verdicts, v};
    endfunction

    function void check_result(cbl_res_t got);
      cbl_res_t want;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result blocked=%0b full_res=%0b", $time,
                 got.blocked, got.full_res);
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.blocked !== want.blocked) begin
        errors++;
        $display("%0t: blocked mismatch, expected %0b actual %0b", $time,
                 want.blocked, got.blocked);
      end
      if (got.full_res !== want.full_res) begin
        errors++;
        $display("%0t: full_res mismatch, expected %0b actual %0b", $time,
                 want.full_res, got.full_res);
      end
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  cbl_req_t req_i;
  logic     done_o;
  cbl_res_t res_o;

  cidr_range_scoreboard sb;
  int unsigned          quiet_cycles;
  int unsigned          adds_issued;

  cidr_block_list_matcher_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (start && !busy) begin
        sb.note_request(req_i);
        quiet_cycles = 0;
      end
      if (done_o) begin
        sb.check_result(res_o);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no request or result for %0d cycles", $time, QuietLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send(cbl_op_e op, logic [AddrW-1:0] a, logic [PlenW-1:0] p);
    cbl_req_t r;
    r.op         = op;
    r.addr       = a;
    r.prefix_len = p;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    if (op == OpAdd) adds_issued++;
  endtask

  task automatic pause(int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic logic [PlenW-1:0] rand_prefix();
    if ($urandom_range(99) < 15) return PlenW'($urandom_range(33, 63));
    return PlenW'($urandom_range(12, 32));
  endfunction

  function automatic logic [AddrW-1:0] probe_addr();
    int unsigned      k;
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
    if (sb.stored == 0 || $urandom_range(99) < 35) return $urandom;
    k  = $urandom_range(sb.stored - 1);
    lo = sb.lo_addr[k];
    hi = sb.hi_addr[k];
    case ($urandom_range(4))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      3: return hi + 1;
      default: return lo | ($urandom & (lo ^ hi));
    endcase
  endfunction

  task automatic run_phase(int unsigned n, int unsigned idle_pct, int unsigned add_pct,
                           int unsigned add_cap);
    for (int unsigned i = 0; i < n; i++) begin
      while ($urandom_range(99) < idle_pct) pause(1);
      if (adds_issued < add_cap && $urandom_range(99) < add_pct) begin
        send(OpAdd, $urandom, add_cap > MaxRanges ? PlenW'($urandom_range(63))
                                                  : rand_prefix());
      end else begin
        send(OpCheck, probe_addr(), PlenW'($urandom_range(63)));
      end
    end
  endtask

  initial begin
    sb           = new();
    quiet_cycles = 0;
    adds_issued  = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    send(OpCheck, 32'h0000_0000, 6'h3F);
    send(OpCheck, 32'hFFFF_FFFF, 6'h00);
    send(OpAdd,   32'hFFFF_FFFF, 6'd32);
    send(OpAdd,   32'h0000_0000, 6'd32);
    send(OpAdd,   32'h0A0B_0C0D, 6'd24);
    send(OpAdd,   32'hC0A8_0001, 6'd33);
    send(OpAdd,   32'h1234_5678, 6'd63);
    send(OpAdd,   32'h8000_0001, 6'd31);
    send(OpCheck, 32'h0000_0000, 6'h00);
    send(OpCheck, 32'hFFFF_FFFF, 6'h3F);
    send(OpCheck, 32'h0000_0001, 6'h15);
    send(OpCheck, 32'hFFFF_FFFE, 6'h2A);
    send(OpCheck, 32'h0A0B_0C00, 6'h00);
    send(OpCheck, 32'h0A0B_0CFF, 6'h00);
    send(OpCheck, 32'h0A0B_0BFF, 6'h00);
    send(OpCheck, 32'h0A0B_0D00, 6'h00);
    send(OpCheck, 32'hC0A8_0001, 6'h00);
    send(OpCheck, 32'hC0A8_0000, 6'h00);
    send(OpCheck, 32'h1234_5678, 6'h00);
    send(OpCheck, 32'h8000_0000, 6'h00);
    send(OpCheck, 32'h8000_0002, 6'h00);

    run_phase(610, 20, 6, MaxRanges - 1);
    run_phase(610, 52, 6, MaxRanges - 1);

    // fill to one free slot, then make the last entry cover every address
    while (adds_issued < MaxRanges - 1) send(OpAdd, $urandom, rand_prefix());
    send(OpAdd, $urandom, 6'd0);
    run_phase(600, 0, 30, MaxRanges + 1000);

    pause(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d adds (%0d dropped on a full list) and %0d checks (%0d blocked).",
             sb.n_adds, sb.n_drops, sb.n_checks, sb.n_hits);
    $display("Sender gaps at 20%% and 52%%, then back-to-back; %0d mismatches.", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
